[rtl/assert_macros.svh]
// Assertion macros shared by the key queue RTL.
// Each macro samples on clk; the first form is also disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk outside reset.
`define FKR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define FKR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/fkr_pkg.sv]
// Package for the key queue: command codes, field widths and cell control.
// Used by the interfaces, the cell and the top level.
`default_nettype none

package fkr_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int KEY_BITS_DEF = 64;
  localparam int KEY_W        = 64;
  localparam int COUNT_W      = 5;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic fire;
    logic push;
    logic pop;
    logic remove;
  } fkr_ctrl_t;

endpackage

`default_nettype wire

[rtl/fkr_req_if.sv]
// Request and response channel interfaces of the key queue.
// Depends on fkr_pkg for the command type and field widths.
`default_nettype none

interface fkr_req_if;
  import fkr_pkg::*;

  logic             valid;
  logic             ready;
  cmd_t             command;
  logic [KEY_W-1:0] key;

  modport source (output valid, output command, output key, input ready);
  modport sink (input valid, input command, input key, output ready);
endinterface

interface fkr_rsp_if;
  import fkr_pkg::*;

  logic               valid;
  logic               ready;
  logic               accepted;
  logic               found;
  logic [KEY_W-1:0]   key_out;
  logic               is_empty;
  logic [COUNT_W-1:0] count;

  modport source (output valid, output accepted, output found, output key_out,
                  output is_empty, output count, input ready);
  modport sink (input valid, input accepted, input found, input key_out,
                input is_empty, input count, output ready);
endinterface

`default_nettype wire

[rtl/fkr_cell.sv]
// One slot of the key queue: holds a key, compares it and shifts from its right neighbor.
// Depends on fkr_pkg for the control struct.
`default_nettype none

module fkr_cell #(
  parameter int DEPTH    = fkr_pkg::DEPTH_DEF,
  parameter int KEY_BITS = fkr_pkg::KEY_BITS_DEF,
  parameter int INDEX    = 0
) (
  input  wire logic                       clk,
  input  wire fkr_pkg::fkr_ctrl_t         ctrl,
  input  wire logic [KEY_BITS-1:0]        key_in,
  input  wire logic [$clog2(DEPTH+1)-1:0] fill,
  input  wire logic                       hit_in,
  input  wire logic [KEY_BITS-1:0]        right_key,
  output logic                            hit_out,
  output logic      [KEY_BITS-1:0]        key
);
  import fkr_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

  logic match;
  logic load;
  logic shift;

  assign match   = (IDX < fill) && (key == key_in);
  assign hit_out = hit_in | match;
  assign load    = ctrl.fire & ctrl.push & (IDX == fill);
  assign shift   = ctrl.fire & (ctrl.pop | (ctrl.remove & hit_out));

  always_ff @(posedge clk) begin
    if (load) begin
      key <= key_in;
    end else if (shift) begin
      key <= right_key;
    end
  end

endmodule

`default_nettype wire

[rtl/fifo_with_keyed_removal.sv]
// Top level of the key queue: a row of slot cells plus fill count and response register.
// Depends on fkr_pkg, fkr_req_if, fkr_rsp_if, fkr_cell and assert_macros.svh.
//
// Usage: requests arrive on req (command and key), one response per request
// leaves on rsp. A push appends at the tail, a pop takes slot 0 and every slot
// moves one place forward, a remove takes the oldest matching slot and the
// slots behind it move forward, a query only looks. All slots compare their
// key against the request key in the same cycle, and a hit ripples down the
// row so that only the oldest match counts.
// Response: the response is registered and is in the output register in the
// cycle after the request is accepted. Throughput: one request per cycle while
// req.ready is high; the row of cells finishes each request in the cycle it is
// accepted, and the search ripple through DEPTH cells sets the path length.
// Stall: req.ready is high while the response register is empty or is being
// taken in the same cycle, so a stalled receiver holds the request side after
// one pending response.
// Reset: rst clears the fill count and the response valid, giving an empty
// queue at once; slot contents are not cleared and are never read unwritten.
`default_nettype none

module fifo_with_keyed_removal #(
  parameter int DEPTH    = fkr_pkg::DEPTH_DEF,
  parameter int KEY_BITS = fkr_pkg::KEY_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  fkr_req_if.sink  req,
  fkr_rsp_if.source rsp
);
  import fkr_pkg::*;
  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  logic [CNT_W-1:0]    count_q;
  logic [CNT_W-1:0]    count_next;
  logic [KEY_BITS-1:0] key_in;
  logic [KEY_BITS-1:0] slot_key [DEPTH];
  logic [DEPTH:0]      hit;
  fkr_ctrl_t           ctrl;
  logic                fire;
  logic                found_any;
  logic                acc_next;
  logic                found_next;
  logic [KEY_W-1:0]    key_out_next;

  logic               rsp_valid;
  logic               rsp_accepted;
  logic               rsp_found;
  logic [KEY_W-1:0]   rsp_key_out;
  logic               rsp_is_empty;
  logic [COUNT_W-1:0] rsp_count;

  assign req.ready = !rsp_valid || rsp.ready;
  assign fire      = req.valid && req.ready;
  assign key_in    = req.key[KEY_BITS-1:0];

  assign ctrl.fire   = fire;
  assign ctrl.push   = (req.command == CMD_PUSH);
  assign ctrl.pop    = (req.command == CMD_POP);
  assign ctrl.remove = (req.command == CMD_REMOVE);

  assign hit[0]    = 1'b0;
  assign found_any = hit[DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0] right_key;
    if (i == DEPTH - 1) begin : g_last
      assign right_key = slot_key[i];
    end else begin : g_mid
      assign right_key = slot_key[i+1];
    end
    fkr_cell #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS),
      .INDEX    (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .key_in    (key_in),
      .fill      (count_q),
      .hit_in    (hit[i]),
      .right_key (right_key),
      .hit_out   (hit[i+1]),
      .key       (slot_key[i])
    );
  end

  always_comb begin
    count_next   = count_q;
    acc_next     = 1'b0;
    found_next   = 1'b0;
    key_out_next = '0;
    unique case (req.command)
      CMD_PUSH: begin
        if (count_q < FULL) begin
          acc_next   = 1'b1;
          count_next = count_q + 1'b1;
        end
      end
      CMD_POP: begin
        if (count_q != '0) begin
          acc_next     = 1'b1;
          key_out_next = KEY_W'(slot_key[0]);
          count_next   = count_q - 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (found_any) begin
          acc_next   = 1'b1;
          count_next = count_q - 1'b1;
        end
      end
      CMD_QUERY: begin
        found_next = found_any;
      end
      default: begin
        count_next = count_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_q   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (fire) begin
        count_q   <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_accepted <= acc_next;
      rsp_found    <= found_next;
      rsp_key_out  <= key_out_next;
      rsp_is_empty <= (count_next == '0);
      rsp_count    <= COUNT_W'(count_next);
    end
  end

  assign rsp.valid    = rsp_valid;
  assign rsp.accepted = rsp_accepted;
  assign rsp.found    = rsp_found;
  assign rsp.key_out  = rsp_key_out;
  assign rsp.is_empty = rsp_is_empty;
  assign rsp.count    = rsp_count;

  `FKR_ASSERT(a_count_bound, count_q <= FULL, "fill count above depth")
  `FKR_ASSERT(a_push_grows, fire && ctrl.push && count_q < FULL |=> count_q == $past(count_q) + 1'b1, "accepted push did not grow the queue")
  `FKR_ASSERT(a_query_holds, fire && req.command == CMD_QUERY |=> $stable(count_q), "query changed the fill count")
  `FKR_ASSERT(a_rsp_count, rsp_valid |-> rsp_count == COUNT_W'(count_q), "response count differs from fill count")

endmodule

`default_nettype wire
